/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Types and codes shared by the tick credit task scheduler modules.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int CR_W  = 16;
  localparam int PRI_W = 8;
  localparam int PRE_W = 8;

  // Command codes
  localparam logic [2:0] FN_ENQ  = 3'd0;
  localparam logic [2:0] FN_RUN  = 3'd1;
  localparam logic [2:0] FN_PRE  = 3'd2;
  localparam logic [2:0] FN_TICK = 3'd3;
  localparam logic [2:0] FN_PICK = 3'd4;
  localparam logic [2:0] FN_CUR  = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_CAP   = 2'd2;
  localparam logic [1:0] STAT_EMPTY = 2'd3;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD,
    ALU_CMP
  } tcs_alu_op_t;

  // Table write request
  typedef struct packed {
    logic                    credit_we;
    logic                    prio_we;
    logic                    preempt_we;
    logic signed [CR_W-1:0]  credit;
    logic [PRI_W-1:0]        prio;
    logic [PRE_W-1:0]        preempt;
  } tcs_wr_t;

endpackage

/* rtl/tcs_alu.sv */
// ----------------------------------------------------------------------------
// tcs_alu
// Shared 17-bit adder: saturating signed add, or signed greater-than compare.
// ----------------------------------------------------------------------------
module tcs_alu
  import tcs_pkg::*;
(
  input  tcs_alu_op_t             op,
  input  logic signed [CR_W-1:0]  a,
  input  logic signed [CR_W-1:0]  b,
  output logic signed [CR_W-1:0]  sum,
  output logic                    gt
);

  logic          sub;
  logic [CR_W:0] a_x;
  logic [CR_W:0] b_x;
  logic [CR_W:0] raw;

  // One adder; compare is a subtract
  always_comb begin
    sub = (op == ALU_CMP);
    a_x = {a[CR_W-1], a};
    b_x = sub ? ~{b[CR_W-1], b} : {b[CR_W-1], b};
    raw = a_x + b_x + (CR_W+1)'(sub);
  end

  // a > b when the difference is positive
  assign gt = !raw[CR_W] && (raw != '0);

  // Clamp to the signed 16-bit range
  always_comb begin
    if (raw[CR_W] != raw[CR_W-1]) begin
      sum = raw[CR_W] ? {1'b1, {(CR_W-1){1'b0}}} : {1'b0, {(CR_W-1){1'b1}}};
    end else begin
      sum = raw[CR_W-1:0];
    end
  end

endmodule

/* rtl/tcs_table.sv */
// ----------------------------------------------------------------------------
// tcs_table
// Task entry memories: credit, priority and preempt count, one write port
// and one registered read port.
// ----------------------------------------------------------------------------
module tcs_table
  import tcs_pkg::*;
#(
  parameter int TASK_SLOTS = 16,
  parameter int IDX_W      = $clog2(TASK_SLOTS)
)(
  input  logic                    clk,
  input  tcs_wr_t                 wr,
  input  logic [IDX_W-1:0]        waddr,
  input  logic [IDX_W-1:0]        raddr,
  output logic signed [CR_W-1:0]  rd_credit,
  output logic [PRI_W-1:0]        rd_prio,
  output logic [PRE_W-1:0]        rd_preempt
);

  logic signed [CR_W-1:0] credit_mem  [TASK_SLOTS];
  logic [PRI_W-1:0]       prio_mem    [TASK_SLOTS];
  logic [PRE_W-1:0]       preempt_mem [TASK_SLOTS];

  // Writes, per field
  always_ff @(posedge clk) begin
    if (wr.credit_we) begin
      credit_mem[waddr] <= wr.credit;
    end
    if (wr.prio_we) begin
      prio_mem[waddr] <= wr.prio;
    end
    if (wr.preempt_we) begin
      preempt_mem[waddr] <= wr.preempt;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_credit  <= credit_mem[raddr];
    rd_prio    <= prio_mem[raddr];
    rd_preempt <= preempt_mem[raddr];
  end

endmodule

/* rtl/tick_credit_task_scheduler.sv */
// ----------------------------------------------------------------------------
// tick_credit_task_scheduler
// Task table with tick credit accounting, first-best pick and decaying
// credit recalculation, run by a small sequencer around one shared adder.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in_       start / busy         in_func .. in_preempt_count
//  out_      out_valid (strobe)   out_chosen_task .. out_status
//  cfg_      cfg_valid/cfg_ready  cfg_main_priority
//
//  Enqueue, set and unused commands: busy stays low, result in the cycle after.
//  Tick: busy in state S_TICK (table read), result strobed the cycle after.
//  Pick: busy through scans and up to MAX_ROUNDS recalc rounds, N = TASK_SLOTS;
//  entries 1..N-1 pass the shared adder once per scan, all N once per recalc.
//  Reset (rst_n low, synchronous) sets the table marks to entry 0 only, no clearing pass.
//  Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tick_credit_task_scheduler
  import tcs_pkg::*;
#(
  parameter int TASK_SLOTS = 16,
  parameter int MAX_ROUNDS = 16
)(
  input  logic                    clk,
  input  logic                    rst_n,
  // command channel
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              in_func,
  input  logic [3:0]              in_target_task,
  input  logic signed [CR_W-1:0]  in_initial_credit,
  input  logic [PRI_W-1:0]        in_task_priority,
  input  logic                    in_running_flag,
  input  logic [PRE_W-1:0]        in_preempt_count,
  // result channel
  output logic                    out_valid,
  output logic [3:0]              out_chosen_task,
  output logic signed [CR_W-1:0]  out_chosen_credit,
  output logic [3:0]              out_current_task,
  output logic                    out_reschedule,
  output logic [1:0]              out_status,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [PRI_W-1:0]        cfg_main_priority
);

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int RND_W = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_RECALC
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    pend_r, pend_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic signed [CR_W-1:0]  best_cr_r, best_cr_nxt;
  logic [RND_W-1:0]        rounds_r, rounds_nxt;
  logic [TASK_SLOTS-1:0]   valid_r, valid_nxt;
  logic [TASK_SLOTS-1:0]   running_r, running_nxt;
  logic [CNT_W-1:0]        nfi_r, nfi_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic signed [CR_W-1:0]  main_cr_r, main_cr_nxt;
  logic [PRE_W-1:0]        main_pre_r, main_pre_nxt;
  logic [PRI_W-1:0]        main_prio_r, main_prio_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [3:0]              out_task_r, out_task_nxt;
  logic signed [CR_W-1:0]  out_cr_r, out_cr_nxt;
  logic                    out_resched_r, out_resched_nxt;
  logic [1:0]              out_status_r, out_status_nxt;

  tcs_wr_t                 wr;
  logic [IDX_W-1:0]        waddr;
  logic [IDX_W-1:0]        raddr;
  logic signed [CR_W-1:0]  tbl_credit;
  logic [PRI_W-1:0]        tbl_prio;
  logic [PRE_W-1:0]        tbl_preempt;

  tcs_alu_op_t             alu_op;
  logic signed [CR_W-1:0]  alu_a;
  logic signed [CR_W-1:0]  alu_b;
  logic signed [CR_W-1:0]  alu_sum;
  logic                    alu_gt;

  logic                    accept;
  logic [IDX_W-1:0]        tgt_idx;
  logic                    tgt_ok;
  logic                    cnt_more;
  logic                    rd_main;
  logic signed [CR_W-1:0]  cr_d;
  logic [PRI_W-1:0]        prio_d;
  logic [PRE_W-1:0]        pre_d;

  tcs_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk        (clk),
    .wr         (wr),
    .waddr      (waddr),
    .raddr      (raddr),
    .rd_credit  (tbl_credit),
    .rd_prio    (tbl_prio),
    .rd_preempt (tbl_preempt)
  );

  tcs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum),
    .gt  (alu_gt)
  );

  // Handshakes and ports
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  assign out_valid         = out_valid_r;
  assign out_chosen_task   = out_task_r;
  assign out_chosen_credit = out_cr_r;
  assign out_current_task  = 4'(cur_r);
  assign out_reschedule    = out_resched_r;
  assign out_status        = out_status_r;

  // Target decode
  assign tgt_idx  = IDX_W'(in_target_task);
  assign tgt_ok   = (32'(in_target_task) < TASK_SLOTS) && valid_r[tgt_idx];
  assign cnt_more = (cnt_r < CNT_W'(TASK_SLOTS));

  // Entry 0 lives in registers; other entries in the table
  assign rd_main = (rd_idx_r == '0);
  assign cr_d    = rd_main ? main_cr_r   : tbl_credit;
  assign prio_d  = rd_main ? main_prio_r : tbl_prio;
  assign pre_d   = rd_main ? main_pre_r  : tbl_preempt;

  // Sequencer next state
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pend_nxt        = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    best_idx_nxt    = best_idx_r;
    best_cr_nxt     = best_cr_r;
    rounds_nxt      = rounds_r;
    valid_nxt       = valid_r;
    running_nxt     = running_r;
    nfi_nxt         = nfi_r;
    cur_nxt         = cur_r;
    main_cr_nxt     = main_cr_r;
    main_pre_nxt    = main_pre_r;
    main_prio_nxt   = main_prio_r;
    out_valid_nxt   = 1'b0;
    out_task_nxt    = out_task_r;
    out_cr_nxt      = out_cr_r;
    out_resched_nxt = out_resched_r;
    out_status_nxt  = out_status_r;
    wr              = '0;
    waddr           = rd_idx_r;
    raddr           = cur_r;
    alu_op          = ALU_CMP;
    alu_a           = cr_d;
    alu_b           = best_cr_r;

    // Configuration write
    if (cfg_valid && cfg_ready) begin
      main_prio_nxt = cfg_main_priority;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt   = 1'b1;
          out_task_nxt    = '0;
          out_cr_nxt      = '0;
          out_resched_nxt = 1'b0;
          out_status_nxt  = STAT_OK;
          case (in_func)
            FN_ENQ: begin
              if (nfi_r >= CNT_W'(TASK_SLOTS)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                waddr                       = nfi_r[IDX_W-1:0];
                wr.credit_we                = 1'b1;
                wr.prio_we                  = 1'b1;
                wr.preempt_we               = 1'b1;
                wr.credit                   = in_initial_credit;
                wr.prio                     = in_task_priority;
                wr.preempt                  = in_preempt_count;
                valid_nxt[nfi_r[IDX_W-1:0]]   = 1'b1;
                running_nxt[nfi_r[IDX_W-1:0]] = in_running_flag;
                nfi_nxt                     = nfi_r + 1'b1;
                out_task_nxt                = 4'(nfi_r);
                out_cr_nxt                  = in_initial_credit;
              end
            end
            FN_RUN, FN_PRE, FN_CUR: begin
              out_task_nxt = in_target_task;
              if (!tgt_ok) begin
                out_status_nxt = STAT_EMPTY;
              end else if (in_func == FN_RUN) begin
                running_nxt[tgt_idx] = in_running_flag;
              end else if (in_func == FN_PRE) begin
                if (tgt_idx == '0) begin
                  main_pre_nxt = in_preempt_count;
                end else begin
                  waddr         = tgt_idx;
                  wr.preempt_we = 1'b1;
                  wr.preempt    = in_preempt_count;
                end
              end else begin
                cur_nxt = tgt_idx;
              end
            end
            FN_TICK: begin
              // table read of the current entry is issued now
              out_valid_nxt = 1'b0;
              rd_idx_nxt    = cur_r;
              state_nxt     = S_TICK;
            end
            FN_PICK: begin
              out_valid_nxt = 1'b0;
              cnt_nxt       = CNT_W'(1);
              best_idx_nxt  = '0;
              best_cr_nxt   = main_cr_r;
              rounds_nxt    = '0;
              state_nxt     = S_SCAN;
            end
            default: begin
              // unused code, plain ok result
            end
          endcase
        end
      end

      S_TICK: begin
        alu_op = ALU_ADD;
        alu_b  = '1;
        if (rd_main) begin
          main_cr_nxt = alu_sum;
        end else begin
          wr.credit_we = 1'b1;
          wr.credit    = alu_sum;
        end
        out_valid_nxt   = 1'b1;
        out_task_nxt    = 4'(rd_idx_r);
        out_cr_nxt      = alu_sum;
        out_resched_nxt = (alu_sum[CR_W-1] || (alu_sum == '0)) && (pre_d == '0);
        out_status_nxt  = STAT_OK;
        state_nxt       = S_IDLE;
      end

      S_SCAN: begin
        // issue the next read while comparing the previous entry
        if (cnt_more) begin
          raddr      = cnt_r[IDX_W-1:0];
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          pend_nxt   = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (valid_r[rd_idx_r] && running_r[rd_idx_r] && alu_gt) begin
            best_idx_nxt = rd_idx_r;
            best_cr_nxt  = cr_d;
          end
        end else if (!cnt_more) begin
          // scan done
          if ((best_cr_r == '0) && (rounds_r < RND_W'(MAX_ROUNDS))) begin
            rounds_nxt = rounds_r + 1'b1;
            cnt_nxt    = '0;
            state_nxt  = S_RECALC;
          end else begin
            out_valid_nxt   = 1'b1;
            out_task_nxt    = 4'(best_idx_r);
            out_cr_nxt      = best_cr_r;
            out_resched_nxt = 1'b0;
            out_status_nxt  = (best_cr_r == '0) ? STAT_CAP : STAT_OK;
            state_nxt       = S_IDLE;
          end
        end
      end

      S_RECALC: begin
        // credit = floor(credit / 2) + priority, saturated
        alu_op = ALU_ADD;
        alu_a  = {cr_d[CR_W-1], cr_d[CR_W-1:1]};
        alu_b  = {{(CR_W-PRI_W){1'b0}}, prio_d};
        if (cnt_more) begin
          raddr      = cnt_r[IDX_W-1:0];
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          pend_nxt   = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (valid_r[rd_idx_r]) begin
            if (rd_main) begin
              main_cr_nxt = alu_sum;
            end else begin
              wr.credit_we = 1'b1;
              wr.credit    = alu_sum;
            end
          end
        end else if (!cnt_more) begin
          cnt_nxt      = CNT_W'(1);
          best_idx_nxt = '0;
          best_cr_nxt  = main_cr_r;
          state_nxt    = S_SCAN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      rounds_r      <= '0;
      valid_r       <= TASK_SLOTS'(1);
      running_r     <= TASK_SLOTS'(1);
      nfi_r         <= CNT_W'(1);
      cur_r         <= '0;
      main_cr_r     <= '0;
      main_pre_r    <= '0;
      main_prio_r   <= PRI_W'(1);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      pend_r        <= pend_nxt;
      rounds_r      <= rounds_nxt;
      valid_r       <= valid_nxt;
      running_r     <= running_nxt;
      nfi_r         <= nfi_nxt;
      cur_r         <= cur_nxt;
      main_cr_r     <= main_cr_nxt;
      main_pre_r    <= main_pre_nxt;
      main_prio_r   <= main_prio_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    rd_idx_r      <= rd_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_cr_r     <= best_cr_nxt;
    out_task_r    <= out_task_nxt;
    out_cr_r      <= out_cr_nxt;
    out_resched_r <= out_resched_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Checks
  `include "assert_macros.svh"

  `TCS_ASSERT_IMP(a_main_valid, clk, rst_n, 1'b1, valid_r[0], "main task entry not valid")
  `TCS_ASSERT_IMP(a_nfi_bound, clk, rst_n, 1'b1, nfi_r <= CNT_W'(TASK_SLOTS), "free index overrun")
  `TCS_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid_r, !busy, "result strobed while busy")
  `TCS_ASSERT_IMP(a_strobe_src, clk, rst_n, out_valid_r, $past(start) || $past(busy), "stray result")
  `TCS_ASSERT_NXT(a_pick_busy, clk, rst_n, accept && (in_func == FN_PICK), busy, "pick not started")

endmodule
